// ===== hdl/mmcbm_pkg.sv =====
// Package for the multi-mode cartridge bank mapper: types, constants, ID table.
package mmcbm_pkg;

    localparam int BANK_REG_COUNT = 16;
    localparam int BANK_IDX_W     = 4;
    localparam int ID_TABLE_SIZE  = 8;

    typedef enum logic [1:0] {
        OP_CPU_WRITE = 2'd0,
        OP_CPU_READ  = 2'd1,
        OP_PAT_FETCH = 2'd2,
        OP_TICK      = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        MODE_MMC3   = 3'd0,
        MODE_CNROM  = 3'd1,
        MODE_UNROM  = 3'd2,
        MODE_UNR512 = 3'd3,
        MODE_MMC1   = 3'd4,
        MODE_NONE   = 3'd5,
        MODE_AOROM  = 3'd6,
        MODE_CDREAM = 3'd7
    } mode_t;

    localparam logic [2:0] CFG_MODE_CONTROL = 3'd0;
    localparam logic [2:0] CFG_PRG_MASK     = 3'd1;
    localparam logic [2:0] CFG_PRG_OR       = 3'd2;
    localparam logic [2:0] CFG_PRG_OUTER    = 3'd3;
    localparam logic [2:0] CFG_CHR_CONTROL  = 3'd4;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] address;
        logic [7:0]  data;
    } req_t;

    typedef struct packed {
        logic [13:0] prg_bank;
        logic [8:0]  chr_bank;
        logic        id_valid;
        logic [7:0]  id_byte;
        logic [1:0]  mirroring;
        logic        irq_level;
    } rsp_t;

    typedef struct packed {
        logic [7:0] mode_control;
        logic [7:0] prg_inner_mask;
        logic [4:0] prg_inner_or;
        logic [6:0] prg_outer_page;
        logic [7:0] chr_control;
    } cfg_t;

    // Mapper state after the current request's update, seen by the decode.
    typedef struct packed {
        logic [7:0] command_shift;
        logic [1:0] mirror_select;
        logic [BANK_REG_COUNT*8-1:0] bank_regs;
        logic       irq_pending;
        logic       id_mode;
    } map_state_t;

    function automatic logic [7:0] id_lookup(input logic [2:0] idx);
        case (idx)
            3'd0:    id_lookup = 8'hFA;
            3'd1:    id_lookup = 8'h51;
            3'd2:    id_lookup = 8'h46;
            3'd3:    id_lookup = 8'h43;
            3'd4:    id_lookup = 8'h45;
            3'd5:    id_lookup = 8'h55;
            3'd6:    id_lookup = 8'h58;
            default: id_lookup = 8'h00;
        endcase
    endfunction

endpackage

// ===== hdl/mmcbm_state.sv =====
// Mapper register file: bank registers, MMC1 shifter, scanline IRQ, flash unlock.
module mmcbm_state
    import mmcbm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       req_fire,
    input  req_t       req,
    input  cfg_t       cfg,
    output map_state_t st_next
);

    logic [7:0] command_shift_reg, command_shift_next;
    logic [1:0] mirror_select_reg, mirror_select_next;
    logic [7:0] bank_reg [BANK_REG_COUNT];
    logic [7:0] bank_next [BANK_REG_COUNT];
    logic [7:0] scan_count_reg, scan_count_next;
    logic [7:0] scan_latch_reg, scan_latch_next;
    logic       reload_reg, reload_next;
    logic       irq_en_reg, irq_en_next;
    logic       irq_pend_reg, irq_pend_next;
    logic [1:0] unlock_reg, unlock_next;
    logic       id_mode_reg, id_mode_next;

    logic [15:0] a;
    logic [7:0]  v;
    logic [7:0]  sh;
    logic [6:0]  sh5;
    mode_t       mode;

    assign a    = req.address;
    assign v    = req.data;
    assign mode = mode_t'(cfg.mode_control[2:0]);

    always_comb begin
        command_shift_next = command_shift_reg;
        mirror_select_next = mirror_select_reg;
        for (int i = 0; i < BANK_REG_COUNT; i++) bank_next[i] = bank_reg[i];
        scan_count_next = scan_count_reg;
        scan_latch_next = scan_latch_reg;
        reload_next     = reload_reg;
        irq_en_next     = irq_en_reg;
        irq_pend_next   = irq_pend_reg;
        unlock_next     = unlock_reg;
        id_mode_next    = id_mode_reg;
        sh  = 8'd0;
        sh5 = 7'd0;

        if (opcode_t'(req.opcode) == OP_CPU_WRITE && a[15]) begin
            if (cfg.mode_control[5]) begin
                if (unlock_reg == 2'd0 && a[11:0] == 12'hAAA && v == 8'hAA)
                    unlock_next = 2'd1;
                else if (unlock_reg == 2'd1 && a[11:0] == 12'h555 && v == 8'h55)
                    unlock_next = 2'd2;
                else if (unlock_reg == 2'd2 && a[11:0] == 12'hAAA && v == 8'h90) begin
                    unlock_next  = 2'd0;
                    id_mode_next = 1'b1;
                end else if (v == 8'hF0)
                    id_mode_next = 1'b0;
            end
            case (mode)
                MODE_MMC3: begin
                    case ({a[15:13], a[0]})
                        4'b1000: command_shift_next = v;
                        4'b1001: bank_next[command_shift_reg[BANK_IDX_W-1:0]] = v;
                        4'b1010: mirror_select_next = v[1:0];
                        4'b1100: scan_latch_next = v;
                        4'b1101: reload_next = 1'b1;
                        4'b1110: begin
                            irq_pend_next = 1'b0;
                            irq_en_next   = 1'b0;
                        end
                        4'b1111: irq_en_next = 1'b1;
                        default: ;
                    endcase
                end
                MODE_MMC1: begin
                    if (v[7]) begin
                        command_shift_next = 8'h20;
                        bank_next[0] = 8'd3;
                    end else begin
                        // upper bits left over from another mode shift down too
                        sh = {1'b0, command_shift_reg[7], command_shift_reg[6] | v[0],
                              command_shift_reg[5:1]};
                        command_shift_next = sh;
                        if (sh[0]) begin
                            sh5 = sh[7:1];
                            case (a[14:13])
                                2'd0: begin
                                    mirror_select_next = sh5[1:0];
                                    bank_next[3] = {5'd0, sh[5:3]};
                                end
                                2'd1:    bank_next[0] = {1'b0, sh5};
                                2'd2:    bank_next[1] = {1'b0, sh5};
                                default: bank_next[6] = {1'b0, sh5};
                            endcase
                            command_shift_next = 8'h20;
                        end
                    end
                end
                MODE_AOROM: begin
                    bank_next[6] = {4'd0, v[3:0]};
                    mirror_select_next = v[4] ? 2'd3 : 2'd2;
                end
                MODE_UNROM: bank_next[6] = v;
                MODE_UNR512: begin
                    bank_next[6] = {3'd0, v[4:0]};
                    bank_next[0] = {6'd0, v[6:5]};
                    if (cfg.mode_control[3]) mirror_select_next = v[7] ? 2'd3 : 2'd2;
                end
                MODE_CDREAM: begin
                    bank_next[6] = {6'd0, v[1:0]};
                    bank_next[0] = {4'd0, v[7:4]};
                end
                default: bank_next[0] = {4'd0, v[3:0]};
            endcase
        end else if (opcode_t'(req.opcode) == OP_TICK) begin
            if (scan_count_reg == 8'd0 || reload_reg) begin
                scan_count_next = scan_latch_reg;
                reload_next     = 1'b0;
            end else begin
                scan_count_next = scan_count_reg - 8'd1;
            end
            if (scan_count_reg != 8'd0 && scan_count_next == 8'd0 && irq_en_reg)
                irq_pend_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            command_shift_reg <= '0;
            mirror_select_reg <= '0;
            for (int i = 0; i < BANK_REG_COUNT; i++) bank_reg[i] <= '0;
            scan_count_reg <= '0;
            scan_latch_reg <= '0;
            reload_reg     <= 1'b0;
            irq_en_reg     <= 1'b0;
            irq_pend_reg   <= 1'b0;
            unlock_reg     <= '0;
            id_mode_reg    <= 1'b0;
        end else if (req_fire) begin
            command_shift_reg <= command_shift_next;
            mirror_select_reg <= mirror_select_next;
            for (int i = 0; i < BANK_REG_COUNT; i++) bank_reg[i] <= bank_next[i];
            scan_count_reg <= scan_count_next;
            scan_latch_reg <= scan_latch_next;
            reload_reg     <= reload_next;
            irq_en_reg     <= irq_en_next;
            irq_pend_reg   <= irq_pend_next;
            unlock_reg     <= unlock_next;
            id_mode_reg    <= id_mode_next;
        end
    end

    always_comb begin
        st_next.command_shift = command_shift_next;
        st_next.mirror_select = mirror_select_next;
        for (int i = 0; i < BANK_REG_COUNT; i++) st_next.bank_regs[i*8 +: 8] = bank_next[i];
        st_next.irq_pending = irq_pend_next;
        st_next.id_mode     = id_mode_next;
    end

endmodule

// ===== hdl/mmcbm_decode.sv =====
// Bank decode: PRG and CHR bank, mirroring and ID read from the updated state.
module mmcbm_decode
    import mmcbm_pkg::*;
(
    input  req_t       req,
    input  cfg_t       cfg,
    input  map_state_t st,
    output rsp_t       rsp
);

    logic [7:0]  r [BANK_REG_COUNT];
    logic [6:0]  band;
    logic [13:0] bor, fixed;
    logic [1:0]  w;
    logic [2:0]  c, half;
    logic [7:0]  cand;
    logic [8:0]  cor;
    logic [13:0] prg;
    logic [8:0]  chr;
    logic [15:0] t;
    logic [7:0]  cb;
    logic [3:0]  s;
    logic        c4;
    logic        idv;
    mode_t       mode;

    always_comb begin
        for (int i = 0; i < BANK_REG_COUNT; i++) r[i] = st.bank_regs[i*8 +: 8];
        mode  = mode_t'(cfg.mode_control[2:0]);
        c4    = cfg.mode_control[4];
        band  = {cfg.prg_inner_mask[4:0], 2'b11};
        bor   = {cfg.prg_outer_page, cfg.prg_inner_or, 2'b00};
        fixed = bor | {7'd0, band};
        w     = req.address[14:13];
        c     = req.address[12:10];
        cand  = {cfg.chr_control[6:4], 5'h1F};
        cor   = {cfg.chr_control[1], 8'd0};
        prg   = '0;
        chr   = '0;
        t     = '0;
        cb    = '0;
        s     = '0;
        half  = c;

        case (mode)
            MODE_MMC3, MODE_CNROM: begin
                // 4'hE: fixed second-last, 4'hF: fixed last
                case ({st.command_shift[6], c4, w})
                    4'b0000: s = 4'd6;  4'b0001: s = 4'd7;
                    4'b0010: s = 4'hE;  4'b0011: s = 4'hF;
                    4'b0100: s = 4'd6;  4'b0101: s = 4'd7;
                    4'b0110: s = 4'd8;  4'b0111: s = 4'd9;
                    4'b1000: s = 4'hE;  4'b1001: s = 4'd7;
                    4'b1010: s = 4'd6;  4'b1011: s = 4'hF;
                    4'b1100: s = 4'd8;  4'b1101: s = 4'd7;
                    4'b1110: s = 4'd6;  4'b1111: s = 4'd9;
                    default: s = 4'd0;
                endcase
                if (s == 4'hE)      prg = fixed & ~14'd1;
                else if (s == 4'hF) prg = fixed;
                else                prg = {7'd0, r[s][6:0] & band} | bor;
            end
            MODE_AOROM, MODE_CDREAM: begin
                t   = {6'd0, r[6], w};
                prg = {7'd0, t[6:0] & band} | bor;
            end
            MODE_UNROM, MODE_UNR512: begin
                t = {7'd0, r[6], w[0]};
                if (!w[1])       prg = {7'd0, t[6:0] & band} | bor;
                else if (!w[0])  prg = fixed & ~14'd1;
                else             prg = fixed;
            end
            MODE_MMC1: begin
                if (!r[3][1]) begin
                    t   = {7'd0, r[6][7:1], w};
                    prg = {7'd0, t[6:0] & band} | bor;
                end else if (!r[3][0]) begin
                    if (!w[1]) prg = {7'd0, {5'd0, w} & band} | bor;
                    else begin
                        t   = {7'd0, r[6], w[0]};
                        prg = {7'd0, t[6:0] & band} | bor;
                    end
                end else begin
                    t = {7'd0, r[6], w[0]};
                    if (!w[1])      prg = {7'd0, t[6:0] & band} | bor;
                    else if (!w[0]) prg = fixed & ~14'd1;
                    else            prg = fixed;
                end
            end
            default: prg = '0;
        endcase

        case (mode)
            MODE_MMC3: begin
                half = st.command_shift[7] ? (c ^ 3'd4) : c;
                if (c4) begin
                    case (half)
                        3'd0: cb = r[0];
                        3'd1: cb = r[10];
                        3'd2: cb = r[1];
                        3'd3: cb = r[11];
                        3'd4: cb = r[2];
                        3'd5: cb = r[3];
                        3'd6: cb = r[4];
                        default: cb = r[5];
                    endcase
                    chr = {1'b0, cb & cand} | cor;
                end else if (!half[2]) begin
                    cb  = half[1] ? r[1] : r[0];
                    chr = (({1'b0, cb & cand} | cor) & ~9'd1) | {8'd0, half[0]};
                end else begin
                    case (half[1:0])
                        2'd0: cb = r[2];
                        2'd1: cb = r[3];
                        2'd2: cb = r[4];
                        default: cb = r[5];
                    endcase
                    chr = {1'b0, cb & cand} | cor;
                end
            end
            MODE_CNROM, MODE_UNR512, MODE_CDREAM: begin
                cb  = {r[0][4:0], c};
                chr = {1'b0, cb & cand} | cor;
            end
            MODE_MMC1: begin
                if (!r[3][2]) cb = {r[0][5:1], 1'b0, 2'b00} | {5'd0, c};
                else begin
                    cb = c[2] ? {r[1][5:0], 2'b00} : {r[0][5:0], 2'b00};
                    cb = cb | {6'd0, c[1:0]};
                end
                chr = {1'b0, cb & cand} | cor;
            end
            MODE_NONE: chr = '0;
            default:   chr = {1'b0, {5'd0, c} & cand} | cor;
        endcase

        idv = opcode_t'(req.opcode) == OP_CPU_READ && req.address[15] && st.id_mode;

        rsp.prg_bank = prg;
        rsp.chr_bank = chr;
        rsp.id_valid = idv;
        rsp.id_byte  = idv ? id_lookup(req.address[2:0]) : 8'd0;
        if (mode == MODE_MMC1)           rsp.mirroring = st.mirror_select ^ 2'd2;
        else if (!cfg.mode_control[3])   rsp.mirroring = {1'b0, st.mirror_select[0]};
        else                             rsp.mirroring = st.mirror_select;
        rsp.irq_level = st.irq_pending;
    end

endmodule

// ===== hdl/multi_mode_cartridge_bank_mapper_top.sv =====
// Top level of the multi-mode cartridge bank mapper.
//  channel | dir | handshake              | payload
//  s_      | in  | s_valid / s_ready      | s_data  (req_t)
//  m_      | out | m_valid / m_ready      | m_data  (rsp_t)
//  cfg     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
// One request per cycle unless m_ready stalls; the result appears in the next cycle.
// The state update and bank decode are combinational from the request input to the result register.
// s_ready is low only while a result is held by a stalled m_ready.
// Synchronous active-low reset clears all mapper state and the config registers, but sets prg_inner_mask to 7.
module multi_mode_cartridge_bank_mapper_top
    import mmcbm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  req_t       s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output rsp_t       m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    cfg_t       cfg_reg;
    logic       m_valid_reg;
    rsp_t       m_data_reg;
    logic       fire;
    map_state_t st_next;
    rsp_t       rsp;

    assign s_ready   = !m_valid_reg || m_ready;
    assign fire      = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode_control   <= 8'd0;
            cfg_reg.prg_inner_mask <= 8'd7;
            cfg_reg.prg_inner_or   <= 5'd0;
            cfg_reg.prg_outer_page <= 7'd0;
            cfg_reg.chr_control    <= 8'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_MODE_CONTROL: cfg_reg.mode_control   <= cfg_data;
                CFG_PRG_MASK:     cfg_reg.prg_inner_mask <= cfg_data;
                CFG_PRG_OR:       cfg_reg.prg_inner_or   <= cfg_data[4:0];
                CFG_PRG_OUTER:    cfg_reg.prg_outer_page <= cfg_data[6:0];
                CFG_CHR_CONTROL:  cfg_reg.chr_control    <= cfg_data;
                default: ;
            endcase
        end
    end

    mmcbm_state u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req_fire(fire),
        .req     (s_data),
        .cfg     (cfg_reg),
        .st_next (st_next)
    );

    mmcbm_decode u_decode (
        .req(s_data),
        .cfg(cfg_reg),
        .st (st_next),
        .rsp(rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= rsp;
        end
    end

endmodule

// ===== hdl/mmcbm_checker.sv =====
// Port-level checker for the cartridge bank mapper, bound to the top level.
module mmcbm_checker
    import mmcbm_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input rsp_t m_data,
    input logic m_valid,
    input logic m_ready
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted request gave no result");

    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_id_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.id_valid |-> m_data.id_byte == 8'd0)
        else $error("id byte without id read");

endmodule

bind multi_mode_cartridge_bank_mapper_top mmcbm_checker u_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_data (m_data),
    .m_valid(m_valid),
    .m_ready(m_ready)
);
